>>> hw/rtl/fixed_frame_resync_deframer_top_assert.svh
// Assertion macros for the deframer RTL, used by the sequencer ffrd_ctrl.
// No dependencies; include by bare file name inside a module body.
`ifndef FIXED_FRAME_RESYNC_DEFRAMER_TOP_ASSERT_SVH
`define FIXED_FRAME_RESYNC_DEFRAMER_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFRD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffrd assertion failed");

// Next-cycle implication, disabled during reset.
`define FFRD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffrd assertion failed");

`endif

>>> hw/rtl/ffrd_pkg.sv
// Package for the fixed frame resync deframer: sizes and control types.
// No dependencies.
package ffrd_pkg;

  localparam int FRAME_BYTES = 16;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [1:0] REG_HEAD = 2'd0;
  localparam logic [1:0] REG_TAIL = 2'd1;

  // Controls broadcast from the sequencer to the cell row.
  typedef struct packed {
    logic                   shift;
    logic [FRAME_BYTES-1:0] load;
  } ctrl_t;

endpackage

>>> hw/rtl/ffrd_rx_if.sv
// Receive byte channel: valid/ready handshake with one byte payload.
// No dependencies.
interface ffrd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/ffrd_frame_if.sv
// Frame byte output channel: valid/ready handshake with byte, index, last.
// No dependencies.
interface ffrd_frame_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic [5:0] byte_index;
  logic       last_byte;

  modport source (output valid, output frame_byte, output byte_index,
                  output last_byte, input ready);
  modport sink (input valid, input frame_byte, input byte_index,
                input last_byte, output ready);
endinterface

>>> hw/rtl/ffrd_cell.sv
// One window cell: holds a byte, loads a received byte or takes its
// upper neighbor's byte on a shift. Depends on ffrd_pkg.
module ffrd_cell
  import ffrd_pkg::*;
(
  input  logic       clk,
  input  logic       load,
  input  logic       shift,
  input  logic [7:0] load_data,
  input  logic [7:0] upper_data,
  output logic [7:0] data
);

  always_ff @(posedge clk) begin
    if (load) begin
      data <= load_data;
    end else if (shift) begin
      data <= upper_data;
    end
  end

endmodule

>>> hw/rtl/ffrd_ctrl.sv
// Sequencer for the cell row: fill, check, emit and head search.
// Depends on ffrd_pkg and the assertion macro header.
module ffrd_ctrl
  import ffrd_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             head_hit,
  input  logic             tail_hit,
  output logic [IDX_W-1:0] idx,
  output ctrl_t            ctrl
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_EMIT   = 4'b0100,
    S_SEARCH = 4'b1000
  } state_t;

  state_t           state, state_next;
  logic [CNT_W-1:0] fill, fill_next;
  logic [IDX_W-1:0] idx_next;
  logic             in_fire, out_fire;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid && out_ready;

  always_comb begin
    state_next = state;
    fill_next  = fill;
    idx_next   = idx;
    ctrl.shift = 1'b0;
    ctrl.load  = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctrl.load = FRAME_BYTES'(1) << fill[IDX_W-1:0];
          fill_next = fill + CNT_W'(1);
          if (fill == CNT_W'(FRAME_BYTES - 1)) begin
            state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (head_hit && tail_hit) begin
          idx_next   = '0;
          state_next = S_EMIT;
        end else begin
          // drop position 0, then look for a head at the new front
          ctrl.shift = 1'b1;
          fill_next  = CNT_W'(FRAME_BYTES - 1);
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (fill == '0 || head_hit) begin
          state_next = S_IDLE;
        end else begin
          ctrl.shift = 1'b1;
          fill_next  = fill - CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_fire) begin
          ctrl.shift = 1'b1;
          idx_next   = idx + IDX_W'(1);
          if (idx == IDX_W'(FRAME_BYTES - 1)) begin
            fill_next  = '0;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
        fill_next  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      idx   <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      idx   <= idx_next;
    end
  end

`include "fixed_frame_resync_deframer_top_assert.svh"

  `FFRD_ASSERT_NOW(a_no_shift_on_load, |ctrl.load, !ctrl.shift)
  `FFRD_ASSERT_NOW(a_fill_bound, state == S_IDLE, fill < CNT_W'(FRAME_BYTES))
  `FFRD_ASSERT_NEXT(a_full_checks, in_fire && fill == CNT_W'(FRAME_BYTES - 1),
                    state == S_CHECK)
  `FFRD_ASSERT_NEXT(a_last_empties, out_fire && idx == IDX_W'(FRAME_BYTES - 1),
                    in_ready && fill == '0)

endmodule

>>> hw/rtl/fixed_frame_resync_deframer_top.sv
// Top level of the fixed frame resync deframer: config registers, cell row
// and sequencer. Depends on ffrd_pkg, ffrd_rx_if, ffrd_frame_if, ffrd_cell,
// ffrd_ctrl.
//
// Usage:
//   rx    : sink of received bytes, one byte per transfer.
//   frame : source of validated frames, FRAME_BYTES transfers per frame,
//           byte_index counting from 0 and last_byte on the final one.
//   cfg   : cfg_we/cfg_index/cfg_wdata write head_byte (index 0) and
//           tail_byte (index 1); other indexes are ignored. Write only idle.
// Throughput: bytes that do not fill the window are taken back to back. The
//   byte that fills it is followed by the check state, then either FRAME_BYTES
//   output transfers (one per cycle when frame.ready stays high) or a head
//   search, one cell shift per cycle. The rate is set by the cell row, which
//   moves one position per cycle while a frame.ready stall does not hold it.
// Output start: after the filling byte is taken, the sequencer passes through
//   the check state before frame.valid rises in the emit state.
// rx.ready is low while checking, searching or emitting. A frame.ready
//   stall holds the row and the current output byte in place.
// Reset empties the window and clears head_byte and tail_byte to zero.
module fixed_frame_resync_deframer_top
  import ffrd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  ffrd_rx_if.sink    rx,
  ffrd_frame_if.source frame
);

  logic [7:0]       head_byte, tail_byte;
  logic [7:0]       cell_data [FRAME_BYTES];
  logic [IDX_W-1:0] idx;
  ctrl_t            ctrl;

  // Register writes; an unknown index is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_byte <= '0;
      tail_byte <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_HEAD) begin
        head_byte <= cfg_wdata;
      end else if (cfg_index == REG_TAIL) begin
        tail_byte <= cfg_wdata;
      end
    end
  end

  // Row of cells; cell 0 is the window front and the output byte.
  for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_cell
    logic [7:0] upper;
    if (i == FRAME_BYTES - 1) begin : g_top
      assign upper = 8'h00;
    end else begin : g_mid
      assign upper = cell_data[i+1];
    end
    ffrd_cell u_cell (
      .clk        (clk),
      .load       (ctrl.load[i]),
      .shift      (ctrl.shift),
      .load_data  (rx.rx_byte),
      .upper_data (upper),
      .data       (cell_data[i])
    );
  end

  ffrd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rx.valid),
    .in_ready  (rx.ready),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .head_hit  (cell_data[0] == head_byte),
    .tail_hit  (cell_data[FRAME_BYTES-1] == tail_byte),
    .idx       (idx),
    .ctrl      (ctrl)
  );

  assign frame.frame_byte = cell_data[0];
  assign frame.byte_index = 6'(idx);
  assign frame.last_byte  = (idx == IDX_W'(FRAME_BYTES - 1));

endmodule
